FILE: hdl/skat_pkg.sv
package skat_pkg;

  localparam int KEY_W   = 27;
  localparam int WGT_W   = 11;
  localparam int VAL_W   = 5;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 8;
  localparam int CNT_W   = 8;
  localparam int WSUM_W  = 24;
  localparam int WTOT_W  = 19;
  localparam int AVG_W   = 11;
  localparam int PROD_W  = WGT_W + VAL_W;
  localparam int DVD_W   = 31;
  localparam int DCNT_W  = 5;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [WSUM_W-1:0] WSUM_MAX = '1;
  localparam logic [WTOT_W-1:0] WTOT_MAX = '1;
  localparam logic [AVG_W-1:0]  AVG_MAX  = '1;
  localparam logic [6:0]        AVG_SCALE = 7'd100;

  localparam logic OP_ACC   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISSING  = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  cnt;
    logic [WSUM_W-1:0] wsum;
    logic [WTOT_W-1:0] wtot;
  } entry_t;

endpackage

FILE: hdl/sorted_key_accumulator_table.sv
// A lookup runs a probe and a compare state per binary-search probe, then resolves;
//   an accumulate adds a write-back state and a read/write state pair per entry shifted
//   up (one memory read port, one write port); a query with nonzero weight total adds
//   the bit-serial divider. Throughput: one item at a time; busy stays high until the
//   result beat. The receiver cannot stall.
// Reset (rst, synchronous): occupancy cleared; entry memory left undefined.
module sorted_key_accumulator_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           op,
  input  logic [skat_pkg::KEY_W-1:0]     key,
  input  logic [skat_pkg::WGT_W-1:0]     weight,
  input  logic [skat_pkg::VAL_W-1:0]     value,
  output logic                           done,
  output logic [skat_pkg::STAT_W-1:0]    status,
  output logic [skat_pkg::SLOT_W-1:0]    slot,
  output logic [skat_pkg::CNT_W-1:0]     record_count,
  output logic [skat_pkg::WSUM_W-1:0]    weighted_total,
  output logic [skat_pkg::WTOT_W-1:0]    weight_total,
  output logic [skat_pkg::AVG_W-1:0]     average
);
  import skat_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OW = $clog2(TABLE_DEPTH + 1);
  localparam logic [OW-1:0] DEPTH_O = OW'(TABLE_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_PROBE    = 9'b000000010,
    S_CMP      = 9'b000000100,
    S_RESOLVE  = 9'b000001000,
    S_SHIFT_RD = 9'b000010000,
    S_SHIFT_WR = 9'b000100000,
    S_UPDATE   = 9'b001000000,
    S_DIV      = 9'b010000000,
    S_AVG      = 9'b100000000
  } state_t;

  state_t state;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata;
  entry_t wdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;

  logic [OW-1:0] occ;
  logic [OW-1:0] lo;
  logic [OW-1:0] hi;
  logic [OW-1:0] mid;
  logic [OW-1:0] idx;
  logic          op_q;
  logic [KEY_W-1:0]  key_q;
  logic [WGT_W-1:0]  weight_q;
  logic [PROD_W-1:0] prod_q;
  logic          ins_q;
  entry_t        ent;

  logic [DVD_W-1:0]  dvd;
  logic [WTOT_W-1:0] rem;
  logic [WTOT_W-1:0] dvs;
  logic [DCNT_W-1:0] dcnt;
  logic [WTOT_W:0]   sh;
  logic [WTOT_W+1:0] diff;

  logic              hit;
  logic [CNT_W-1:0]  cnt_next;
  logic [WSUM_W:0]   wsum_sum;
  logic [WTOT_W:0]   wtot_sum;
  entry_t            upd;

  assign busy = (state != S_IDLE);
  assign mid  = lo + ((hi - lo) >> 1);
  assign hit  = (lo < occ) && (rdata.key == key_q);

  assign cnt_next = (ent.cnt == CNT_MAX) ? ent.cnt : ent.cnt + 1'b1;
  assign wsum_sum = {1'b0, ent.wsum} + (WSUM_W + 1)'(prod_q);
  assign wtot_sum = {1'b0, ent.wtot} + (WTOT_W + 1)'(weight_q);
  always_comb begin
    upd      = ent;
    upd.cnt  = cnt_next;
    upd.wsum = wsum_sum[WSUM_W] ? WSUM_MAX : wsum_sum[WSUM_W-1:0];
    upd.wtot = wtot_sum[WTOT_W] ? WTOT_MAX : wtot_sum[WTOT_W-1:0];
  end

  assign sh   = {rem, dvd[DVD_W-1]};
  assign diff = {1'b0, sh} - {2'b00, dvs};

  always_comb begin
    raddr = AW'(mid);
    unique case (state)
      S_PROBE:    raddr = (lo < hi) ? AW'(mid) : AW'(lo);
      S_SHIFT_RD: raddr = AW'(idx - 1'b1);
      default:    raddr = AW'(mid);
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(lo);
    wdata = upd;
    unique case (state)
      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = AW'(idx);
        wdata = rdata;
      end
      S_UPDATE: begin
        we    = 1'b1;
        waddr = AW'(lo);
        wdata = upd;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q     <= op;
            key_q    <= key;
            weight_q <= weight;
            prod_q   <= PROD_W'(value) * PROD_W'(weight);
            lo       <= '0;
            hi       <= occ;
            state    <= S_PROBE;
          end
        end
        S_PROBE: begin
          state <= (lo < hi) ? S_CMP : S_RESOLVE;
        end
        S_CMP: begin
          if (rdata.key < key_q) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
          state <= S_PROBE;
        end
        S_RESOLVE: begin
          if (op_q == OP_QUERY) begin
            if (!hit) begin
              done           <= 1'b1;
              status         <= ST_MISSING;
              slot           <= '0;
              record_count   <= '0;
              weighted_total <= '0;
              weight_total   <= '0;
              average        <= '0;
              state          <= S_IDLE;
            end else if (rdata.wtot == '0) begin
              done           <= 1'b1;
              status         <= ST_FOUND;
              slot           <= SLOT_W'(lo);
              record_count   <= rdata.cnt;
              weighted_total <= rdata.wsum;
              weight_total   <= rdata.wtot;
              average        <= '0;
              state          <= S_IDLE;
            end else begin
              ent   <= rdata;
              dvd   <= DVD_W'(rdata.wsum) * DVD_W'(AVG_SCALE);
              dvs   <= rdata.wtot;
              rem   <= '0;
              dcnt  <= '0;
              state <= S_DIV;
            end
          end else if (hit) begin
            ent   <= rdata;
            ins_q <= 1'b0;
            state <= S_UPDATE;
          end else if (occ == DEPTH_O) begin
            done           <= 1'b1;
            status         <= ST_FULL;
            slot           <= '0;
            record_count   <= '0;
            weighted_total <= '0;
            weight_total   <= '0;
            average        <= '0;
            state          <= S_IDLE;
          end else begin
            ins_q <= 1'b1;
            ent   <= '{key: key_q, cnt: '0, wsum: '0, wtot: '0};
            idx   <= occ;
            state <= (occ == lo) ? S_UPDATE : S_SHIFT_RD;
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx   <= idx - 1'b1;
          state <= ((idx - 1'b1) == lo) ? S_UPDATE : S_SHIFT_RD;
        end
        S_UPDATE: begin
          if (ins_q) begin
            occ <= occ + 1'b1;
          end
          done           <= 1'b1;
          status         <= ins_q ? ST_INSERTED : ST_UPDATED;
          slot           <= SLOT_W'(lo);
          record_count   <= upd.cnt;
          weighted_total <= upd.wsum;
          weight_total   <= upd.wtot;
          average        <= '0;
          state          <= S_IDLE;
        end
        S_DIV: begin
          if (!diff[WTOT_W+1]) begin
            rem <= diff[WTOT_W-1:0];
            dvd <= {dvd[DVD_W-2:0], 1'b1};
          end else begin
            rem <= sh[WTOT_W-1:0];
            dvd <= {dvd[DVD_W-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(DVD_W - 1)) begin
            state <= S_AVG;
          end
        end
        S_AVG: begin
          done           <= 1'b1;
          status         <= ST_FOUND;
          slot           <= SLOT_W'(lo);
          record_count   <= ent.cnt;
          weighted_total <= ent.wsum;
          weight_total   <= ent.wtot;
          average        <= (dvd > DVD_W'(AVG_MAX)) ? AVG_MAX : dvd[AVG_W-1:0];
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/skat_checker.sv
module skat_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           op,
  input logic [skat_pkg::KEY_W-1:0]     key,
  input logic [skat_pkg::WGT_W-1:0]     weight,
  input logic [skat_pkg::VAL_W-1:0]     value,
  input logic                           done,
  input logic [skat_pkg::STAT_W-1:0]    status,
  input logic [skat_pkg::SLOT_W-1:0]    slot,
  input logic [skat_pkg::CNT_W-1:0]     record_count,
  input logic [skat_pkg::WSUM_W-1:0]    weighted_total,
  input logic [skat_pkg::WTOT_W-1:0]    weight_total,
  input logic [skat_pkg::AVG_W-1:0]     average
);
  import skat_pkg::*;

  // accepted beat keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  // result beat follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without prior work");

  a_avg_query_only: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_FOUND) |-> (average == '0))
    else $error("average set on non-query result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL || status == ST_MISSING)) |->
      (slot == '0 && record_count == '0 && weighted_total == '0 && weight_total == '0))
    else $error("dropped or missing result carries data");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_FULL && status != ST_MISSING) |-> (record_count != '0))
    else $error("live entry with zero record count");

endmodule

bind sorted_key_accumulator_table skat_checker u_skat_checker (.*);
